// File: sv/wsp_pkg.sv
// Shared types and constants for the waveform step plotter.
`default_nettype none

package wsp_pkg;

    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int COORD_BITS_DEF  = 12;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 17;
    localparam int SIZE_W   = 13;
    localparam int COLOR_W  = 24;
    localparam int CFG_IDX_W = 2;

    // Full scale of a sample is 2^15.
    localparam int FULL_SCALE_SHIFT = 15;

    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = COUNT_W'(1024);
    localparam logic [SIZE_W-1:0]  PLOT_WIDTH_RST   = SIZE_W'(640);
    localparam logic [SIZE_W-1:0]  PLOT_HEIGHT_RST  = SIZE_W'(480);
    localparam logic [COLOR_W-1:0] LINE_COLOR_RST   = COLOR_W'(24'h00FF00);

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_HRUN  = 2'd1,
        KIND_VRUN  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_PLOT_WIDTH   = 2'd1,
        CFG_PLOT_HEIGHT  = 2'd2,
        CFG_LINE_COLOR   = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

// File: sv/wsp_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module wsp_div #(
    parameter int DIVISOR_W = 17,
    parameter int QUOT_W    = 12
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIVISOR_W-1:0] dividend_hi,
    input  wire logic [QUOT_W-1:0]    dividend_lo,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      done,
    output logic [QUOT_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0]    low_reg, low_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               ge;

    // The upper part of the dividend is below the divisor, so the
    // remainder always fits the divisor width.
    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend_hi;
            low_next  = dividend_lo;
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            low_next = {low_reg[QUOT_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

`default_nettype wire

// File: sv/waveform_step_plotter.sv
// Top level of the waveform step plotter: sequencer, row mapping and output register.
//
//   Channel   Handshake                  Payload
//   cfg       cfg_wr_en                  cfg_index, cfg_data
//   in        in_valid / in_ready        sample, first
//   out       out_valid / out_ready      kind, x_start, x_end, y_start, y_end, color, last
//
// Each sample passes through the multiply, row, divide and decide states before its
// first result; the serial divider produces one column bit per cycle.
// A sample gives up to three results, one from each emit state.
// in_ready is high only while the sequencer is idle. A stalled out_ready holds the
// sequencer in its emit state. Reset clears the sequencer, the trace state and the
// configuration registers to their power-up values; no clearing pass is needed.
`default_nettype none

module waveform_step_plotter #(
    parameter int MAX_SAMPLES = wsp_pkg::MAX_SAMPLES_DEF,
    parameter int COORD_BITS  = wsp_pkg::COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wsp_pkg::COLOR_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [wsp_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                          first,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output wsp_pkg::kind_t                     kind,
    output logic [COORD_BITS-1:0]              x_start,
    output logic [COORD_BITS-1:0]              x_end,
    output logic [COORD_BITS-1:0]              y_start,
    output logic [COORD_BITS-1:0]              y_end,
    output logic [wsp_pkg::COLOR_W-1:0]        color,
    output logic                               last
);

    import wsp_pkg::*;

    localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
    localparam int SZ_W  = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
    localparam int PX_W  = IDX_W + COORD_BITS;
    localparam int PY_W  = COORD_BITS + 1 + SAMPLE_W;
    localparam logic [SZ_W-1:0] COORD_MAX = SZ_W'((1 << COORD_BITS) - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROW,
        ST_DIV,
        ST_DECIDE,
        ST_HRUN,
        ST_VRUN,
        ST_POINT
    } state_t;

    // Configuration registers.
    logic [COUNT_W-1:0] sample_count_reg;
    logic [SIZE_W-1:0]  plot_width_reg;
    logic [SIZE_W-1:0]  plot_height_reg;
    logic [COLOR_W-1:0] line_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            plot_width_reg   <= PLOT_WIDTH_RST;
            plot_height_reg  <= PLOT_HEIGHT_RST;
            line_color_reg   <= LINE_COLOR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_PLOT_WIDTH:   plot_width_reg   <= cfg_data[SIZE_W-1:0];
                CFG_PLOT_HEIGHT:  plot_height_reg  <= cfg_data[SIZE_W-1:0];
                CFG_LINE_COLOR:   line_color_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    function automatic logic [COORD_BITS-1:0] size_less_one(input logic [SIZE_W-1:0] r);
        logic [SZ_W-1:0] v;
        v = SZ_W'(r) - SZ_W'(1);
        if (r == '0)
            return '0;
        else if (v > COORD_MAX)
            return COORD_MAX[COORD_BITS-1:0];
        else
            return v[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0] w1;
    logic [COORD_BITS-1:0] h1;
    logic [CMP_W-1:0]      count_ext;
    logic [IDX_W-1:0]      count;

    assign w1        = size_less_one(plot_width_reg);
    assign h1        = size_less_one(plot_height_reg);
    assign count_ext = CMP_W'(sample_count_reg);
    assign count     = (count_ext > CMP_W'(MAX_SAMPLES)) ? IDX_W'(MAX_SAMPLES)
                                                         : count_ext[IDX_W-1:0];

    // Sequencer and trace state.
    state_t state_reg, state_next;
    logic [IDX_W-1:0]      sample_index_reg, sample_index_next;
    logic                  have_start_reg, have_start_next;
    logic [COORD_BITS-1:0] start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic signed [SAMPLE_W-1:0] s_reg, s_next;
    logic [PX_W-1:0]       prod_x_reg, prod_x_next;
    logic signed [PY_W-1:0] prod_y_reg, prod_y_next;
    logic [COORD_BITS-1:0] y_reg, y_next;
    logic [COORD_BITS-1:0] x_reg, x_next;
    logic                  plot_pt_reg, plot_pt_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    kind_t                 kind_reg, kind_next;
    logic [COORD_BITS-1:0] xs_reg, xs_next;
    logic [COORD_BITS-1:0] xe_reg, xe_next;
    logic [COORD_BITS-1:0] ys_reg, ys_next;
    logic [COORD_BITS-1:0] ye_reg, ye_next;
    logic [COLOR_W-1:0]    color_reg, color_next;
    logic                  last_reg, last_next;

    logic                  div_start;
    logic                  div_done;
    logic [COORD_BITS-1:0] div_quot;

    wsp_div #(
        .DIVISOR_W (IDX_W),
        .QUOT_W    (COORD_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend_hi (prod_x_reg[PX_W-1:COORD_BITS]),
        .dividend_lo (prod_x_reg[COORD_BITS-1:0]),
        .divisor     (count),
        .done        (div_done),
        .quotient    (div_quot)
    );

    logic [IDX_W-1:0]       idx_now;
    logic signed [PY_W-1:0] biased;
    logic signed [PY_W-1:0] scaled;
    logic signed [PY_W-1:0] row_diff;
    logic                   slot_free;

    assign idx_now = first ? '0 : sample_index_reg;

    // Truncating division by full scale: bias negative products before the shift.
    assign biased   = prod_y_reg + (prod_y_reg[PY_W-1]
                      ? PY_W'((1 << FULL_SCALE_SHIFT) - 1) : PY_W'(0));
    assign scaled   = biased >>> FULL_SCALE_SHIFT;
    assign row_diff = $signed(PY_W'(h1)) - scaled;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_ROW);

    always_comb
    begin
        state_next        = state_reg;
        sample_index_next = sample_index_reg;
        have_start_next   = have_start_reg;
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        i_next            = i_reg;
        s_next            = s_reg;
        prod_x_next       = prod_x_reg;
        prod_y_next       = prod_y_reg;
        y_next            = y_reg;
        x_next            = x_reg;
        plot_pt_next      = plot_pt_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        kind_next         = kind_reg;
        xs_next           = xs_reg;
        xe_next           = xe_reg;
        ys_next           = ys_reg;
        ye_next           = ye_reg;
        color_next        = color_reg;
        last_next         = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (first)
                        have_start_next = 1'b0;
                    i_next = idx_now;
                    s_next = sample;
                    if (IDX_W'(MAX_SAMPLES) > idx_now)
                        sample_index_next = idx_now + IDX_W'(1);
                    else
                        sample_index_next = idx_now;
                    if (idx_now < count)
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_x_next = PX_W'(i_reg) * PX_W'(w1);
                prod_y_next = $signed(PY_W'(h1)) * PY_W'(s_reg);
                state_next  = ST_ROW;
            end
            ST_ROW:
            begin
                y_next       = row_diff[COORD_BITS:1];
                plot_pt_next = ({1'b0, i_reg} + (IDX_W + 1)'(1)) < {1'b0, count};
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    x_next     = div_quot;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!have_start_reg)
                begin
                    have_start_next = 1'b1;
                    start_x_next    = x_reg;
                    start_y_next    = y_reg;
                    state_next      = plot_pt_reg ? ST_POINT : ST_IDLE;
                end
                else if (y_reg == start_y_reg)
                begin
                    // A flat pair plots nothing more; the next sample opens a new pair.
                    have_start_next = 1'b0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HRUN;
                end
            end
            ST_HRUN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_HRUN;
                    xs_next        = start_x_reg;
                    xe_next        = x_reg;
                    ys_next        = start_y_reg;
                    ye_next        = start_y_reg;
                    color_next     = line_color_reg;
                    last_next      = 1'b0;
                    state_next     = ST_VRUN;
                end
            end
            ST_VRUN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_VRUN;
                    xs_next        = x_reg;
                    xe_next        = x_reg;
                    ys_next        = start_y_reg;
                    ye_next        = y_reg;
                    color_next     = line_color_reg;
                    last_next      = !plot_pt_reg;
                    start_x_next   = x_reg;
                    start_y_next   = y_reg;
                    state_next     = plot_pt_reg ? ST_POINT : ST_IDLE;
                end
            end
            ST_POINT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_POINT;
                    xs_next        = x_reg;
                    xe_next        = x_reg;
                    ys_next        = y_reg;
                    ye_next        = y_reg;
                    color_next     = line_color_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_index_reg <= '0;
            have_start_reg   <= 1'b0;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sample_index_reg <= sample_index_next;
            have_start_reg   <= have_start_next;
            start_x_reg      <= start_x_next;
            start_y_reg      <= start_y_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        s_reg       <= s_next;
        prod_x_reg  <= prod_x_next;
        prod_y_reg  <= prod_y_next;
        y_reg       <= y_next;
        x_reg       <= x_next;
        plot_pt_reg <= plot_pt_next;
        kind_reg    <= kind_next;
        xs_reg      <= xs_next;
        xe_reg      <= xe_next;
        ys_reg      <= ys_next;
        ye_reg      <= ye_next;
        color_reg   <= color_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign x_start   = xs_reg;
    assign x_end     = xe_reg;
    assign y_start   = ys_reg;
    assign y_end     = ye_reg;
    assign color     = color_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
